// ----- sv/pstk_pkg.sv -----
// shared types and constants of the priority stack
`default_nettype none

package pstk_pkg;

  // fixed field widths of the channel words
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 4;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // number of priority levels a push may name
  localparam int NUM_LEVELS = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LEVEL_HIGH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

  // reset value of the max_level register
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 4'd15;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0] level;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [VALUE_W-1:0]  top_value;
    logic [LEVEL_W-1:0]  top_level;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [LEVEL_W-1:0] level;
  } cell_cmd_t;

  // occupancy and level of one cell as its neighbors see it
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } cell_state_t;

endpackage

`default_nettype wire

// ----- sv/priority_stack.sv -----
// priority stack top level: control, count, result register and the cell row
// the result word is registered and valid in the cycle after its input word is accepted
// throughput: one word per clock while no result is held up by out_stall; every cell decides
//   hold, load or shift from its two neighbors and the broadcast command
// reset: synchronous, active low; clears every cell's occupancy flag
//   and the element count and sets max_level to 15
`default_nettype none

module priority_stack #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire pstk_pkg::in_word_t            in_word,
  output logic                               out_valid,
  input  wire                                out_stall,
  output pstk_pkg::out_word_t                out_word,
  input  wire                                cfg_we,
  input  wire [pstk_pkg::LEVEL_W-1:0]        cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [pstk_pkg::LEVEL_W:0] LEVEL_LIMIT =
    (pstk_pkg::LEVEL_W + 1)'(pstk_pkg::NUM_LEVELS);

  logic [pstk_pkg::LEVEL_W-1:0] max_level_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         out_valid_r;
  pstk_pkg::out_word_t          out_word_r, res;

  logic                         accept, do_push, do_pop, lvl_high, full, empty;
  logic [pstk_pkg::STATUS_W-1:0] status;
  pstk_pkg::cell_cmd_t          cmd;
  logic [VALUE_BITS-1:0]        new_val;

  logic                         top_valid;
  logic [pstk_pkg::LEVEL_W-1:0] top_level;
  logic [VALUE_BITS-1:0]        top_val;
  logic [pstk_pkg::VALUE_W-1:0] top_val32;
  logic [pstk_pkg::COUNT_W-1:0] count9;

  // cell row with a blank position at each end
  pstk_pkg::cell_state_t st_ext  [CAPACITY+2];
  logic [VALUE_BITS-1:0] val_ext [CAPACITY+2];
  logic                  ins_w   [CAPACITY];
  logic                  prev_ins_w [CAPACITY];

  assign st_ext[0]           = '0;
  assign val_ext[0]          = '0;
  assign st_ext[CAPACITY+1]  = '0;
  assign val_ext[CAPACITY+1] = '0;

  // input value to stored width
  if (VALUE_BITS > pstk_pkg::VALUE_W) begin : g_in_wide
    assign new_val = {{(VALUE_BITS - pstk_pkg::VALUE_W){1'b0}}, in_word.value};
  end else if (VALUE_BITS == pstk_pkg::VALUE_W) begin : g_in_same
    assign new_val = in_word.value;
  end else begin : g_in_narrow
    assign new_val = in_word.value[VALUE_BITS-1:0];
  end

  // stored width to result value
  if (VALUE_BITS > pstk_pkg::VALUE_W) begin : g_out_wide
    assign top_val32 = top_val[pstk_pkg::VALUE_W-1:0];
  end else if (VALUE_BITS == pstk_pkg::VALUE_W) begin : g_out_same
    assign top_val32 = top_val;
  end else begin : g_out_narrow
    assign top_val32 = {{(pstk_pkg::VALUE_W - VALUE_BITS){1'b0}}, top_val};
  end

  // count to result width
  if (CW > pstk_pkg::COUNT_W) begin : g_cnt_wide
    assign count9 = count_nxt[pstk_pkg::COUNT_W-1:0];
  end else if (CW == pstk_pkg::COUNT_W) begin : g_cnt_same
    assign count9 = count_nxt;
  end else begin : g_cnt_narrow
    assign count9 = {{(pstk_pkg::COUNT_W - CW){1'b0}}, count_nxt};
  end

  // handshake: input waits only while a result is held up
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // decode and checks
  always_comb begin
    lvl_high = (in_word.level > max_level_r) || ({1'b0, in_word.level} >= LEVEL_LIMIT);
    full     = (count_r == CAP_CNT);
    empty    = (count_r == '0);
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status   = pstk_pkg::ST_OK;
    case (in_word.opcode)
      pstk_pkg::OP_PUSH: begin
        if (lvl_high) begin
          status = pstk_pkg::ST_LEVEL_HIGH;
        end else if (full) begin
          status = pstk_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      pstk_pkg::OP_POP: begin
        if (empty) begin
          status = pstk_pkg::ST_POP_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      pstk_pkg::OP_QUERY: begin
        status = pstk_pkg::ST_OK;
      end
      default: begin
        status = pstk_pkg::ST_OK;
      end
    endcase
    cmd.push  = do_push && accept;
    cmd.pop   = do_pop && accept;
    cmd.level = in_word.level;
  end

  // element count after the operation
  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // front cell after the operation
  always_comb begin
    top_valid = st_ext[1].valid;
    top_level = st_ext[1].level;
    top_val   = val_ext[1];
    if (do_push) begin
      if (ins_w[0]) begin
        top_valid = 1'b1;
        top_level = in_word.level;
        top_val   = new_val;
      end
    end else if (do_pop) begin
      top_valid = st_ext[2].valid;
      top_level = st_ext[2].level;
      top_val   = val_ext[2];
    end
  end

  // result word
  always_comb begin
    res.top_value = top_valid ? top_val32 : '0;
    res.top_level = top_valid ? top_level : '0;
    res.count     = count9;
    res.is_empty  = (count_nxt == '0);
    res.status    = status;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      max_level_r <= pstk_pkg::MAX_LEVEL_RST;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        max_level_r <= cfg_wdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // the cell row, front element in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_ins_w[i] = 1'b0;
    end else begin : g_rest
      assign prev_ins_w[i] = ins_w[i-1];
    end

    pstk_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (cmd),
      .new_value_i  (new_val),
      .prev_i       (st_ext[i]),
      .prev_value_i (val_ext[i]),
      .prev_ins_i   (prev_ins_w[i]),
      .next_i       (st_ext[i+2]),
      .next_value_i (val_ext[i+2]),
      .state_o      (st_ext[i+1]),
      .value_o      (val_ext[i+1]),
      .ins_o        (ins_w[i])
    );
  end

endmodule

`default_nettype wire

// ----- sv/pstk_cell.sv -----
// one cell of the sorted row: holds one element, shifts with its neighbors
`default_nettype none

module pstk_cell #(
  parameter int VALUE_BITS = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire pstk_pkg::cell_cmd_t  cmd_i,
  input  wire [VALUE_BITS-1:0]      new_value_i,
  input  wire pstk_pkg::cell_state_t prev_i,
  input  wire [VALUE_BITS-1:0]      prev_value_i,
  input  wire                       prev_ins_i,
  input  wire pstk_pkg::cell_state_t next_i,
  input  wire [VALUE_BITS-1:0]      next_value_i,
  output pstk_pkg::cell_state_t     state_o,
  output logic [VALUE_BITS-1:0]     value_o,
  output logic                      ins_o
);

  logic                         valid_r, valid_nxt;
  logic [pstk_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [VALUE_BITS-1:0]        value_r, value_nxt;

  // new element belongs at or ahead of this cell: free, or not above its level
  assign ins_o = !valid_r || (level_r <= cmd_i.level);

  // hold, load the new element, or shift from a neighbor
  always_comb begin
    valid_nxt = valid_r;
    level_nxt = level_r;
    value_nxt = value_r;
    if (cmd_i.push) begin
      if (ins_o) begin
        if (prev_ins_i) begin
          valid_nxt = prev_i.valid;
          level_nxt = prev_i.level;
          value_nxt = prev_value_i;
        end else begin
          valid_nxt = 1'b1;
          level_nxt = cmd_i.level;
          value_nxt = new_value_i;
        end
      end
    end else if (cmd_i.pop) begin
      valid_nxt = next_i.valid;
      level_nxt = next_i.level;
      value_nxt = next_value_i;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // element payload
  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    value_r <= value_nxt;
  end

  assign state_o.valid = valid_r;
  assign state_o.level = level_r;
  assign value_o       = value_r;

endmodule

`default_nettype wire

// ----- sv/pstk_checker.sv -----
// port-level checks of the priority stack and their binding
`default_nettype none

module pstk_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire pstk_pkg::out_word_t out_word
);

  // a held-up result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // input is held back only by a result waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_empty |-> out_word.count == '0)
    else $error("empty flag with nonzero count");

  // empty store shows a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_empty |->
      out_word.top_value == '0 && out_word.top_level == '0)
    else $error("empty store shows a top element");

  // a pop on empty leaves the store empty
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == pstk_pkg::ST_POP_EMPTY |-> out_word.is_empty)
    else $error("pop-on-empty status with elements stored");

endmodule

bind priority_stack pstk_checker u_pstk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ----- verif/priority_stack_test.sv -----
// self-checking testbench for the priority stack: directed and random words with result checks
`timescale 1ns / 100ps

module priority_stack_test;

  localparam int STACK_DEPTH = 256;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  // opcode 3 is not assigned and behaves as a query
  localparam logic [pstk_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  pstk_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pstk_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [pstk_pkg::LEVEL_W-1:0] cfg_wdata = '0;

  // words waiting to be sent, appended by the sequencer and walked by the driver
  pstk_pkg::in_word_t pending[$];
  int send_idx = 0;
  int send_gap = 0;
  int send_calm = 0;
  logic in_taken = 1'b0;

  // receiver state
  int recv_stall_left = 0;
  int recv_calm = 0;
  int backlog_left = 0;
  logic backlog_done = 1'b0;

  // stack image: one lifo per level, newest at the back
  logic [pstk_pkg::VALUE_W-1:0] level_vals[pstk_pkg::NUM_LEVELS][$];
  int elem_count = 0;
  logic [pstk_pkg::LEVEL_W-1:0] level_limit = pstk_pkg::MAX_LEVEL_RST;

  // expected result words, oldest first
  pstk_pkg::out_word_t exp_q[$];
  int accepted_words = 0;
  int results_checked = 0;
  int err_count = 0;
  int status_tally[4];
  int quiet_cycles = 0;
  logic [pstk_pkg::LEVEL_W-1:0] mixed_limit;

  priority_stack #(
    .CAPACITY(STACK_DEPTH),
    .VALUE_BITS(pstk_pkg::VALUE_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // gap length: mostly none, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // highest level holding anything, -1 when the stack is empty
  function automatic int highest_level();
    for (int i = pstk_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_vals[i].size() != 0) return i;
    end
    return -1;
  endfunction

  // apply one word to the stack image and build the result it should produce
  function automatic pstk_pkg::out_word_t stack_apply(pstk_pkg::in_word_t w);
    pstk_pkg::out_word_t r;
    int top;
    r = '0;
    r.status = pstk_pkg::ST_OK;
    if (w.opcode == pstk_pkg::OP_PUSH) begin
      if (w.level > level_limit) begin
        r.status = pstk_pkg::ST_LEVEL_HIGH;
      end else if (elem_count >= STACK_DEPTH) begin
        r.status = pstk_pkg::ST_FULL;
      end else begin
        level_vals[w.level].push_back(w.value);
        elem_count++;
      end
    end else if (w.opcode == pstk_pkg::OP_POP) begin
      top = highest_level();
      if (top < 0) begin
        r.status = pstk_pkg::ST_POP_EMPTY;
      end else begin
        void'(level_vals[top].pop_back());
        elem_count--;
      end
    end
    // levels above a lowered limit still count for the top
    top = highest_level();
    if (top >= 0) begin
      r.top_value = level_vals[top][$];
      r.top_level = (pstk_pkg::LEVEL_W)'(top);
    end
    r.count = (pstk_pkg::COUNT_W)'(elem_count);
    r.is_empty = (elem_count == 0);
    return r;
  endfunction

  task automatic check_result(pstk_pkg::out_word_t got, pstk_pkg::out_word_t want);
    if (got.top_value !== want.top_value) begin
      $error("top_value: expected %h, got %h", want.top_value, got.top_value);
      err_count++;
    end
    if (got.top_level !== want.top_level) begin
      $error("top_level: expected %0d, got %0d", want.top_level, got.top_level);
      err_count++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      err_count++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
      err_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_count++;
    end
  endtask

  task automatic queue_word(logic [pstk_pkg::OP_W-1:0] op,
                            logic [pstk_pkg::VALUE_W-1:0] value,
                            logic [pstk_pkg::LEVEL_W-1:0] level);
    pstk_pkg::in_word_t w;
    w.opcode = op;
    w.value = value;
    w.level = level;
    pending.push_back(w);
  endtask

  // wait until every queued word is in and every result is out
  task automatic drain_wait();
    while (accepted_words != pending.size() || exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_level(logic [pstk_pkg::LEVEL_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random words with a given push and pop share; the rest are queries of both kinds
  task automatic random_phase(int n, int push_pct, int pop_pct);
    int r;
    logic [pstk_pkg::OP_W-1:0] op;
    logic [pstk_pkg::VALUE_W-1:0] value;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) op = pstk_pkg::OP_PUSH;
      else if (r < push_pct + pop_pct) op = pstk_pkg::OP_POP;
      else if ($urandom_range(0, 1) == 0) op = pstk_pkg::OP_QUERY;
      else op = OP_SPARE;
      r = $urandom_range(0, 9);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      else value = $urandom;
      queue_word(op, value,
                 (pstk_pkg::LEVEL_W)'($urandom_range(0, pstk_pkg::NUM_LEVELS - 1)));
    end
  endtask

  // word driver: a stalled word holds, otherwise send the next one after its gap
  always @(negedge clk) begin : word_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled word stays put
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (send_idx < pending.size()) begin
      in_word <= pending[send_idx];
      in_valid <= 1'b1;
      send_idx++;
      if (send_calm > 0) begin
        send_calm--;
        send_gap = 0;
      end else begin
        send_gap = idle_len();
        if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: random stalls, calm stretches and one long backlog hold
  always @(negedge clk) begin : result_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (backlog_left > 0) begin
      backlog_left--;
      out_stall <= 1'b1;
    end else if (!backlog_done && results_checked >= 100) begin
      backlog_done = 1'b1;
      backlog_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (recv_stall_left > 0) begin
      recv_stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(20, 80);
      else if ($urandom_range(0, 2) == 0) recv_stall_left = idle_len();
    end
  end

  // monitor: predict on each accepted word, compare each accepted result
  always @(posedge clk) begin : stack_monitor
    pstk_pkg::out_word_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        want = stack_apply(in_word);
        status_tally[want.status]++;
        exp_q.push_back(want);
        accepted_words++;
      end
      if (cfg_we) level_limit = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          $error("result word with no expectation waiting");
          err_count++;
        end else begin
          check_result(out_word, exp_q.pop_front());
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sequencer
  initial begin : sequencer
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stack, both query opcodes, lifo within a level, list end
    @(posedge clk);
    queue_word(pstk_pkg::OP_POP, 32'h0, 4'd0);
    queue_word(pstk_pkg::OP_QUERY, 32'hFFFF_FFFF, 4'd15);
    queue_word(OP_SPARE, 32'h0, 4'd0);
    queue_word(pstk_pkg::OP_PUSH, 32'h0000_0000, 4'd0);
    queue_word(pstk_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd15);
    queue_word(pstk_pkg::OP_PUSH, 32'h1234_5678, 4'd15);
    queue_word(OP_SPARE, 32'hFFFF_FFFF, 4'd15);
    queue_word(pstk_pkg::OP_POP, 32'h0, 4'd0);
    queue_word(pstk_pkg::OP_POP, 32'h0, 4'd0);
    queue_word(pstk_pkg::OP_PUSH, 32'hA5A5_A5A5, 4'd12);
    queue_word(pstk_pkg::OP_PUSH, 32'h5A5A_5A5A, 4'd12);
    drain_wait();

    // lowered limit: level 12 stays visible, pushes above the limit bounce
    write_max_level(4'd3);
    @(posedge clk);
    queue_word(pstk_pkg::OP_PUSH, 32'h0BAD_F00D, 4'd12);
    queue_word(pstk_pkg::OP_PUSH, 32'h0BAD_F00D, 4'd4);
    queue_word(pstk_pkg::OP_PUSH, 32'hDEAD_BEEF, 4'd3);
    repeat (5) queue_word(pstk_pkg::OP_POP, 32'h0, 4'd0);
    drain_wait();

    // limit at its floor
    write_max_level(4'd0);
    @(posedge clk);
    queue_word(pstk_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd0);
    queue_word(pstk_pkg::OP_PUSH, 32'h0000_0001, 4'd1);
    queue_word(pstk_pkg::OP_QUERY, 32'h0, 4'd0);
    queue_word(pstk_pkg::OP_POP, 32'h0, 4'd0);
    drain_wait();

    // fill past capacity, then churn, drain past empty, churn again
    write_max_level(4'd15);
    random_phase(320, 95, 3);
    drain_wait();
    write_max_level(4'd9);
    random_phase(100, 50, 40);
    drain_wait();
    write_max_level(4'd0);
    random_phase(280, 5, 95);
    drain_wait();
    mixed_limit = (pstk_pkg::LEVEL_W)'($urandom_range(1, 14));
    write_max_level(mixed_limit);
    random_phase(75, 55, 35);
    drain_wait();

    repeat (5) @(negedge clk);
    if (exp_q.size() != 0) $error("%0d expected results never arrived", exp_q.size());
    $display("run: %0d words sent, %0d results compared, max_level 15/3/0/15/9/0/%0d",
             accepted_words, results_checked, mixed_limit);
    $display("statuses: %0d ok, %0d level too high, %0d pop on empty, %0d full",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (err_count == 0 && exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
